// ===== rtl/lcre_pkg.sv =====
// Shared types and constants for the line center unit.
// Depends on nothing; used by lcre_front, lcre_back and the top level.
package lcre_pkg;

    // Widths fixed by the pixel and kernel formats
    localparam int PIX_W  = 8;
    localparam int TAP_W  = 8;
    localparam int PROD_W = PIX_W + TAP_W;
    localparam int RESP_W = PROD_W + 1;
    localparam int ROW_W  = 10;
    localparam int CIDX_W = 10;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_LEFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_MID   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_RIGHT = 2'd2;

    // Reset values of the kernel
    localparam logic signed [TAP_W-1:0] TAP_LEFT_RST  = -8'sd1;
    localparam logic signed [TAP_W-1:0] TAP_MID_RST   = 8'sd0;
    localparam logic signed [TAP_W-1:0] TAP_RIGHT_RST = 8'sd1;

    typedef struct packed {
        logic signed [TAP_W-1:0] tap_left;
        logic signed [TAP_W-1:0] tap_mid;
        logic signed [TAP_W-1:0] tap_right;
    } taps_t;

    // Fixed part of one classified pixel handed from front to back
    typedef struct packed {
        logic                     resp_valid;
        logic                     last;
        logic signed [RESP_W-1:0] value;
        logic [ROW_W-1:0]         row;
    } resp_t;

endpackage

// ===== rtl/lcre_fifo.sv =====
// Small first-in first-out buffer of flat words.
// Depends on nothing; used between front and back and on the result side.
module lcre_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic         full,
    input  logic         rd_en,
    output logic [W-1:0] rd_data,
    output logic         empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/lcre_front.sv =====
// Front end: takes pixels, keeps the row window and count, forms the kernel response.
// Depends on lcre_pkg.
module lcre_front #(
    parameter int ROW_MAX = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 accept,
    input  logic signed [lcre_pkg::PIX_W-1:0]    pixel,
    input  logic [lcre_pkg::ROW_W-1:0]           row_number,
    input  logic                                 end_of_row,
    input  lcre_pkg::taps_t                      taps,
    output lcre_pkg::resp_t                      ent,
    output logic [$clog2(ROW_MAX)-1:0]           ent_idx,
    output logic [$clog2(ROW_MAX)-1:0]           ent_trail
);
    import lcre_pkg::*;

    localparam int IW = $clog2(ROW_MAX);
    localparam int CW = $clog2(ROW_MAX + 1);

    logic signed [PIX_W-1:0]  win0_reg, win0_next;
    logic signed [PIX_W-1:0]  win1_reg, win1_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     in_row;
    logic signed [PROD_W-1:0] p0, p1, p2;

    assign in_row = (count_reg < CW'(ROW_MAX));

    // Three-tap kernel on the two held pixels and the new one
    assign p0 = taps.tap_left  * win0_reg;
    assign p1 = taps.tap_mid   * win1_reg;
    assign p2 = taps.tap_right * pixel;

    always_comb
    begin
        ent.resp_valid = in_row && (count_reg >= CW'(2));
        ent.last       = end_of_row;
        ent.value      = RESP_W'(p0) + RESP_W'(p1) + RESP_W'(p2);
        ent.row        = row_number;
        ent_idx        = IW'(count_reg - CW'(2));
        // Index of the first trailing zero response of the row
        ent_trail      = in_row ? IW'(count_reg - CW'(1)) : IW'(ROW_MAX - 2);
    end

    // Window shift and row count; cleared when the row closes
    always_comb
    begin
        win0_next  = win0_reg;
        win1_next  = win1_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (end_of_row)
            begin
                win0_next  = '0;
                win1_next  = '0;
                count_next = '0;
            end
            else if (in_row)
            begin
                win0_next  = win1_reg;
                win1_next  = pixel;
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg  <= '0;
            win1_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            win0_reg  <= win0_next;
            win1_reg  <= win1_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/lcre_back.sv =====
// Back end: tracks the first strongest rising and falling responses, emits the midpoint.
// Depends on lcre_pkg.
module lcre_back #(
    parameter int ROW_MAX = 1024
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              ent_avail,
    input  lcre_pkg::resp_t                   ent,
    input  logic [$clog2(ROW_MAX)-1:0]        ent_idx,
    input  logic [$clog2(ROW_MAX)-1:0]        ent_trail,
    output logic                              ent_take,
    input  logic                              res_room,
    output logic                              res_push,
    output logic [lcre_pkg::CIDX_W-1:0]       res_index,
    output logic [lcre_pkg::ROW_W-1:0]        res_row
);
    import lcre_pkg::*;

    localparam int IW = $clog2(ROW_MAX);
    localparam int SW = (IW + 1 > CIDX_W + 1) ? IW + 1 : CIDX_W + 1;

    logic                     have_reg, have_next;
    logic signed [RESP_W-1:0] hi_v_reg, hi_v_next, lo_v_reg, lo_v_next;
    logic [IW-1:0]            hi_i_reg, hi_i_next, lo_i_reg, lo_i_next;
    logic [IW-1:0]            hi_sel, lo_sel;
    logic [SW-1:0]            sum;

    // A closing entry waits for room on the result side
    assign ent_take = ent_avail && (!ent.last || res_room);
    assign res_push = ent_take && ent.last;

    // Running extremes, first one wins on ties
    always_comb
    begin
        have_next = have_reg;
        hi_v_next = hi_v_reg;
        hi_i_next = hi_i_reg;
        lo_v_next = lo_v_reg;
        lo_i_next = lo_i_reg;
        if (ent.resp_valid)
        begin
            if (!have_reg)
            begin
                have_next = 1'b1;
                hi_v_next = ent.value;
                hi_i_next = ent_idx;
                lo_v_next = ent.value;
                lo_i_next = ent_idx;
            end
            else
            begin
                if (ent.value > hi_v_reg)
                begin
                    hi_v_next = ent.value;
                    hi_i_next = ent_idx;
                end
                if (ent.value < lo_v_reg)
                begin
                    lo_v_next = ent.value;
                    lo_i_next = ent_idx;
                end
            end
        end
    end

    // Trailing zero response overrides a negative maximum or positive minimum
    always_comb
    begin
        hi_sel = '0;
        lo_sel = '0;
        if (have_next)
        begin
            hi_sel = (hi_v_next < 0) ? ent_trail : hi_i_next;
            lo_sel = (lo_v_next > 0) ? ent_trail : lo_i_next;
        end
        sum       = SW'(hi_sel) + SW'(lo_sel);
        res_index = sum[CIDX_W:1];
        res_row   = ent.row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
            hi_v_reg <= '0;
            hi_i_reg <= '0;
            lo_v_reg <= '0;
            lo_i_reg <= '0;
        end
        else if (ent_take)
        begin
            if (ent.last)
            begin
                have_reg <= 1'b0;
                hi_v_reg <= '0;
                hi_i_reg <= '0;
                lo_v_reg <= '0;
                lo_i_reg <= '0;
            end
            else
            begin
                have_reg <= have_next;
                hi_v_reg <= hi_v_next;
                hi_i_reg <= hi_i_next;
                lo_v_reg <= lo_v_next;
                lo_i_reg <= lo_i_next;
            end
        end
    end

endmodule

// ===== rtl/line_center_from_row_edges_unit.sv =====
// Line center unit: top level with kernel registers, front, back and queues.
// Depends on lcre_pkg, lcre_fifo, lcre_front and lcre_back.
//
// Usage:
//   Pixels of a row enter left to right on the push/full side, one request per
//   cycle while full is low; end_of_row marks the last pixel and closes the row.
//   Each closed row gives one result (center_index, center_row) on the
//   empty/pop side; it stays on the ports while empty is low until popped.
//   Kernel taps are written through cfg_valid/cfg_ready/cfg_index/cfg_data
//   (index 0 left, 1 middle, 2 right; other indexes are ignored) while idle.
// Timing:
//   One pixel per cycle sustained while full is low. The kernel response is formed
//   at accept and lands in a two-entry queue; the back end takes it from there,
//   updates the extremes and writes the result into a two-entry result queue,
//   from which the result is shown on the ports.
//   If pop is held low, results collect; once the result queue is full the back
//   end holds the next closing pixel, the middle queue fills and full rises.
// Reset: queues empty, row state cleared, taps return to -1, 0, 1.
module line_center_from_row_edges_unit #(
    parameter int ROW_MAX = 1024
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [lcre_pkg::PIX_W-1:0]   pixel,
    input  logic [lcre_pkg::ROW_W-1:0]          row_number,
    input  logic                                end_of_row,
    output logic                                empty,
    input  logic                                pop,
    output logic [lcre_pkg::CIDX_W-1:0]         center_index,
    output logic [lcre_pkg::ROW_W-1:0]          center_row,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lcre_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic signed [lcre_pkg::TAP_W-1:0]   cfg_data
);
    import lcre_pkg::*;

    localparam int IW     = $clog2(ROW_MAX);
    localparam int RBITS  = $bits(resp_t);
    localparam int MID_W  = RBITS + 2 * IW;
    localparam int RES_W  = CIDX_W + ROW_W;

    taps_t             taps_reg, taps_next;
    logic              accept;
    resp_t             f_ent, b_ent;
    logic [IW-1:0]     f_idx, f_trail, b_idx, b_trail;
    logic [MID_W-1:0]  mid_rd;
    logic              mid_empty, b_take;
    logic              res_full, res_push;
    logic [CIDX_W-1:0] res_index;
    logic [ROW_W-1:0]  res_row;
    logic [RES_W-1:0]  res_rd;

    // Kernel registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        taps_next = taps_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TAP_LEFT:  taps_next.tap_left  = cfg_data;
                CFG_TAP_MID:   taps_next.tap_mid   = cfg_data;
                CFG_TAP_RIGHT: taps_next.tap_right = cfg_data;
                default:       taps_next = taps_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg.tap_left  <= TAP_LEFT_RST;
            taps_reg.tap_mid   <= TAP_MID_RST;
            taps_reg.tap_right <= TAP_RIGHT_RST;
        end
        else
        begin
            taps_reg <= taps_next;
        end
    end

    // Front end
    assign accept = push && !full;

    lcre_front #(.ROW_MAX(ROW_MAX)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .pixel      (pixel),
        .row_number (row_number),
        .end_of_row (end_of_row),
        .taps       (taps_reg),
        .ent        (f_ent),
        .ent_idx    (f_idx),
        .ent_trail  (f_trail)
    );

    // Queue between front and back
    lcre_fifo #(.W(MID_W), .DEPTH(2)) u_mid_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data ({f_ent, f_idx, f_trail}),
        .full    (full),
        .rd_en   (b_take),
        .rd_data (mid_rd),
        .empty   (mid_empty)
    );

    assign b_ent   = mid_rd[MID_W-1 -: RBITS];
    assign b_idx   = mid_rd[2*IW-1 -: IW];
    assign b_trail = mid_rd[IW-1:0];

    // Back end
    lcre_back #(.ROW_MAX(ROW_MAX)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ent_avail (!mid_empty),
        .ent       (b_ent),
        .ent_idx   (b_idx),
        .ent_trail (b_trail),
        .ent_take  (b_take),
        .res_room  (!res_full),
        .res_push  (res_push),
        .res_index (res_index),
        .res_row   (res_row)
    );

    // Result queue
    lcre_fifo #(.W(RES_W), .DEPTH(2)) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data ({res_index, res_row}),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign center_index = res_rd[RES_W-1 -: CIDX_W];
    assign center_row   = res_rd[ROW_W-1:0];

endmodule
